### hdl/w36tx_pkg.sv
// ----------------------------------------------------------------------------
// w36tx_pkg
// shared types, constants and mode codes for the 36-bit word text unpacker
// ----------------------------------------------------------------------------
package w36tx_pkg;

  localparam int unsigned NumBytes   = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CharW      = 7;
  localparam int unsigned CountW     = 3;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned QueueDepth = 2;

  // output_mode codes, code 3 acts as plain text
  localparam logic [ModeW-1:0] ModePlain    = 2'd0;
  localparam logic [ModeW-1:0] ModeFold     = 2'd1;
  localparam logic [ModeW-1:0] ModeRaw      = 2'd2;
  localparam logic [ModeW-1:0] ModePlainAlt = 2'd3;

  localparam logic [ByteW-1:0] ChCr  = 8'h0D;
  localparam logic [ByteW-1:0] ChLf  = 8'h0A;
  localparam logic [ByteW-1:0] ChNul = 8'h00;

  // one classified word as it waits between front and back
  typedef struct packed {
    logic [NumBytes-1:0][ByteW-1:0] chars;    // characters or raw bytes
    logic [CountW-1:0]              count;    // characters kept, 1..5
    logic [ModeW-1:0]               mode;
    logic                           first;    // word starts a file
    logic                           tail_cr;  // last kept character is cr
  } entry_t;

  // back end status, watched by the checks in the top level
  typedef struct packed {
    logic              step;
    logic              pending;
    logic [CountW-1:0] idx;
  } back_sts_t;

endpackage

### hdl/word36_to_ascii_text_extract.sv
// ----------------------------------------------------------------------------
// word36_to_ascii_text_extract
// unpacks 36-bit file words from tape bytes into text or raw bytes
// ----------------------------------------------------------------------------
// usage
//   in channel: one transaction per 36-bit word, five tape bytes plus the
//   first_word / final_word file markers
//   out channel: one transaction per character, last_of_run_o set on the
//   final character a word produces; a word may produce none in fold mode
//   cfg channel: writes output_mode, always ready, write only while idle
// the first character of a word is registered in the queue entry and
//   then in the output register before it shows on out_valid_o
// throughput: the back end takes one step per kept character plus one
//   per held cr that is released; a word keeps 1 to 5 characters in
//   plain and fold mode and all 5 in raw mode; a step that holds a cr
//   gives no output, otherwise the output register passes one character
//   per cycle while the receiver is ready
// a two-entry queue lets words keep arriving while the back end is busy;
//   a stalled receiver holds the output register, then the queue fills and
//   in_ready_o drops
// reset: queue emptied, output register empty, held cr cleared, mode plain
// ----------------------------------------------------------------------------
module word36_to_ascii_text_extract #(
  parameter int unsigned QueueDepth = w36tx_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [w36tx_pkg::ModeW-1:0] cfg_data_i,
  // word input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [w36tx_pkg::ByteW-1:0] byte_0_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_1_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_2_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_3_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_4_i,
  input  logic                        first_word_i,
  input  logic                        final_word_i,
  // character output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [w36tx_pkg::ByteW-1:0] out_byte_o,
  output logic                        last_of_run_o
);

  logic [w36tx_pkg::ModeW-1:0] mode_q;
  w36tx_pkg::entry_t front_entry;
  w36tx_pkg::entry_t head;
  w36tx_pkg::back_sts_t sts;
  logic q_full, q_push, q_pop, head_valid;

  // output_mode register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= w36tx_pkg::ModePlain;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // front: classify the word as it is accepted
  w36tx_front u_front (
    .byte_0_i     (byte_0_i),
    .byte_1_i     (byte_1_i),
    .byte_2_i     (byte_2_i),
    .byte_3_i     (byte_3_i),
    .byte_4_i     (byte_4_i),
    .first_word_i (first_word_i),
    .final_word_i (final_word_i),
    .mode_i       (mode_q),
    .entry_o      (front_entry)
  );

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  // queue between front and back
  w36tx_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: character sequencer and output register
  w36tx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .sts_o         (sts)
  );

`ifndef SYNTHESIS
  // the character index stays inside the kept characters of the head word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (sts.idx < head.count))
    else $error("character index beyond kept count");

  // a cr is only held back in fold mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.step && !sts.pending && head.mode != w36tx_pkg::ModeFold) |=> !sts.pending)
    else $error("cr held outside fold mode");

  // a new file outside fold mode leaves no cr held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.step && head.first && sts.idx == '0 && head.mode != w36tx_pkg::ModeFold)
      |=> !sts.pending)
    else $error("held cr survived file start");

  // the queue is only popped from a valid head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

### hdl/w36tx_front.sv
// ----------------------------------------------------------------------------
// w36tx_front
// splits a word into characters, trims trailing nuls of a final non-raw word, tags the entry
// ----------------------------------------------------------------------------
module w36tx_front (
  input  logic [w36tx_pkg::ByteW-1:0] byte_0_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_1_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_2_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_3_i,
  input  logic [w36tx_pkg::ByteW-1:0] byte_4_i,
  input  logic                        first_word_i,
  input  logic                        final_word_i,
  input  logic [w36tx_pkg::ModeW-1:0] mode_i,
  output w36tx_pkg::entry_t           entry_o
);

  logic [35:0] word;
  logic [w36tx_pkg::NumBytes-1:0][w36tx_pkg::ByteW-1:0] txt;
  logic [w36tx_pkg::NumBytes-1:0] zero;
  logic [w36tx_pkg::CountW-1:0] trail;
  logic [w36tx_pkg::CountW-1:0] cnt;
  logic is_raw;

  assign word = {byte_0_i, byte_1_i, byte_2_i, byte_3_i, byte_4_i[3:0]};

  // five 7-bit characters, word bit 0 dropped
  assign txt[0] = {1'b0, word[35:29]};
  assign txt[1] = {1'b0, word[28:22]};
  assign txt[2] = {1'b0, word[21:15]};
  assign txt[3] = {1'b0, word[14:8]};
  assign txt[4] = {1'b0, word[7:1]};

  assign is_raw = (mode_i == w36tx_pkg::ModeRaw);

  always_comb begin
    for (int i = 0; i < w36tx_pkg::NumBytes; i++) begin
      zero[i] = (txt[i] == w36tx_pkg::ChNul);
    end
  end

  // trailing nuls, at most four
  always_comb begin
    trail = 3'd0;
    if (final_word_i && !is_raw && zero[4]) begin
      trail = 3'd1;
      if (zero[3]) begin
        trail = 3'd2;
        if (zero[2]) begin
          trail = 3'd3;
          if (zero[1]) begin
            trail = 3'd4;
          end
        end
      end
    end
  end

  assign cnt = 3'd5 - trail;

  always_comb begin
    entry_o.count   = cnt;
    entry_o.mode    = mode_i;
    entry_o.first   = first_word_i;
    if (is_raw) begin
      entry_o.chars = {byte_4_i, byte_3_i, byte_2_i, byte_1_i, byte_0_i};
    end else begin
      entry_o.chars = txt;
    end
    entry_o.tail_cr = (txt[cnt - 3'd1] == w36tx_pkg::ChCr);
  end

endmodule

### hdl/w36tx_fifo.sv
// ----------------------------------------------------------------------------
// w36tx_fifo
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module w36tx_fifo #(
  parameter int unsigned Depth = w36tx_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  w36tx_pkg::entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output w36tx_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  w36tx_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;

  assign full_o       = (level_q == LvlW'(Depth));
  assign head_valid_o = (level_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      level_d = level_q + LvlW'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/w36tx_back.sv
// ----------------------------------------------------------------------------
// w36tx_back
// steps through the head word one character a cycle unless the output stalls or a held cr is released, folds cr lf
// ----------------------------------------------------------------------------
module w36tx_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  w36tx_pkg::entry_t           head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [w36tx_pkg::ByteW-1:0] out_byte_o,
  output logic                        last_of_run_o,
  output w36tx_pkg::back_sts_t        sts_o
);

  logic [w36tx_pkg::CountW-1:0] idx_q, idx_d;
  logic pending_q, pending_d;
  logic out_valid_q, out_valid_d;
  logic [w36tx_pkg::ByteW-1:0] out_byte_q, out_byte_d;
  logic out_last_q, out_last_d;

  logic step, last_idx, pend_eff, more;
  logic emit, emit_last, adv, pend_next;
  logic [w36tx_pkg::ByteW-1:0] c, emit_byte;
  logic [w36tx_pkg::CountW-1:0] cnt_m1;

  assign step     = head_valid_i && (!out_valid_q || out_ready_i);
  assign cnt_m1   = head_i.count - 3'd1;
  assign last_idx = (idx_q == cnt_m1);
  assign c        = head_i.chars[idx_q];
  // a new file drops any held cr
  assign pend_eff = pending_q && !((idx_q == '0) && head_i.first);
  // later output exists once a non-cr or two characters remain
  assign more     = !last_idx && ((idx_q + 3'd1 != cnt_m1) || !head_i.tail_cr);

  always_comb begin
    emit      = 1'b1;
    emit_byte = c;
    emit_last = last_idx;
    adv       = 1'b1;
    pend_next = pend_eff;
    unique case (head_i.mode)
      w36tx_pkg::ModeFold: begin
        if (pend_eff && (c != w36tx_pkg::ChLf)) begin
          // held cr goes out ahead of this character
          emit_byte = w36tx_pkg::ChCr;
          emit_last = (c == w36tx_pkg::ChCr) && last_idx;
          adv       = 1'b0;
          pend_next = 1'b0;
        end else if (c == w36tx_pkg::ChCr) begin
          emit      = 1'b0;
          pend_next = 1'b1;
        end else begin
          emit_last = !more;
          pend_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    pending_d   = pending_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (step) begin
      pending_d = pend_next;
      if (adv) begin
        if (last_idx) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      if (emit) begin
        out_valid_d = 1'b1;
        out_byte_d  = emit_byte;
        out_last_d  = emit_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

  assign sts_o.step    = step;
  assign sts_o.pending = pending_q;
  assign sts_o.idx     = idx_q;

endmodule
